// File: hdl/aes128_block_cipher_unit_defines.svh
// Assertion macros for the checker module of the AES-128 unit.
// Depends on nothing; included by the checker module.
`ifndef AES128_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define AES128_BLOCK_CIPHER_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hdl/aes_pkg.sv
// Package of the AES-128 unit: operation codes, S-box tables and round helpers.
// Has no dependencies; used by aes_round and the top level.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

  typedef enum logic [1:0] {
    KIND_ENC  = 2'd0,
    KIND_DEC  = 2'd1,
    KIND_CTR  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  localparam int unsigned NumRounds = 10;

  typedef logic [127:0] block_t;

  // Control that travels down the pipeline next to the state.
  typedef struct packed {
    logic  vld;
    kind_t kind;
  } stage_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // No GF(2^8) inverse is shared by the two tables: affine maps around one would be
  // smaller, but the inverse S-box is written here as a search over a table, by
  // inverting the forward one through a 256-way compare.
  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (sbox(8'(i)) == a) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the block sits in bits 127-8i : 120-8i.
  function automatic logic [7:0] get_b(input block_t s, input int unsigned i);
    return s[8'(127 - 8 * i) -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8'(127 - 8 * (4 * c + r)) -: 8] = sbox(get_b(s, 4 * ((c + r) % 4) + r));
      end
    end
    return t;
  endfunction

  function automatic block_t inv_sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8'(127 - 8 * (4 * ((c + r) % 4) + r)) -: 8] = inv_sbox(get_b(s, 4 * c + r));
      end
    end
    return t;
  endfunction

  function automatic block_t mix_fwd(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(s, 4 * c);
      a1 = get_b(s, 4 * c + 1);
      a2 = get_b(s, 4 * c + 2);
      a3 = get_b(s, 4 * c + 3);
      t[8'(127 - 32 * c) -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[8'(119 - 32 * c) -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[8'(111 - 32 * c) -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[8'(103 - 32 * c) -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

  function automatic block_t mix_inv(input block_t s);
    block_t t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j]  = get_b(s, 4 * c + j);
        x2[j] = xtime(a[j]);
        x4[j] = xtime(x2[j]);
        x8[j] = xtime(x4[j]);
        m9[j] = x8[j] ^ a[j];
        mb[j] = x8[j] ^ x2[j] ^ a[j];
        md[j] = x8[j] ^ x4[j] ^ a[j];
        me[j] = x8[j] ^ x4[j] ^ x2[j];
      end
      t[8'(127 - 32 * c) -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      t[8'(119 - 32 * c) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      t[8'(111 - 32 * c) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      t[8'(103 - 32 * c) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    end
    return t;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] i);
    logic [7:0] r;
    unique case (i)
      4'd0: r = 8'h01; 4'd1: r = 8'h02; 4'd2: r = 8'h04; 4'd3: r = 8'h08;
      4'd4: r = 8'h10; 4'd5: r = 8'h20; 4'd6: r = 8'h40; 4'd7: r = 8'h80;
      4'd8: r = 8'h1b; 4'd9: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // One step of the key schedule: round key i+1 from round key i, using rcon(i).
  function automatic block_t key_step(input block_t k, input logic [3:0] i);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t  = {sbox(k[23:16]) ^ rcon(i), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

// File: hdl/aes_round.sv
// One pipelined AES round stage: encrypt and decrypt datapaths, registered.
// Depends on aes_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aes_round (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  wire                 last,
  input  aes_pkg::stage_ctl_t ctl_in,
  input  aes_pkg::block_t     st_in,
  input  aes_pkg::block_t     cnt_in,
  input  aes_pkg::block_t     dat_in,
  input  aes_pkg::block_t     enc_key,
  input  aes_pkg::block_t     dec_key,
  output aes_pkg::stage_ctl_t ctl_out,
  output aes_pkg::block_t     st_out,
  output aes_pkg::block_t     cnt_out,
  output aes_pkg::block_t     dat_out
);
  import aes_pkg::*;

  stage_ctl_t ctl_r;
  block_t     st_r, cnt_r, dat_r, st_nxt, e_t, d_t;

  always_comb begin
    e_t = sub_shift(st_in);
    d_t = inv_sub_shift(st_in);
    if (!last) begin
      e_t = mix_fwd(e_t);
      d_t = mix_inv(d_t);
    end
    st_nxt = (ctl_in.kind == KIND_DEC) ? (d_t ^ dec_key) : (e_t ^ enc_key);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
    if (en) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_in;
      dat_r <= dat_in;
    end
  end

  assign ctl_out = ctl_r;
  assign st_out  = st_r;
  assign cnt_out = cnt_r;
  assign dat_out = dat_r;
endmodule
`default_nettype wire

// File: hdl/aes128_block_cipher_unit.sv
// AES-128 ECB/CTR unit. An input transfer loads the key-add stage; the data then
// passes ten round stages and the output register, each registered in turn.
// Throughput: one item per cycle; the whole pipeline stalls when the output
// register is full and not taken. Key writes expand the schedule step by step;
// no input is taken during the expansion. Synchronous active-low reset clears
// valid bits and keys; round keys are undefined until the first key write.
`timescale 1ns / 1ps
`default_nettype none
module aes128_block_cipher_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [0:0]  cfg_index,
  input  wire  [63:0] cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_kind,
  input  wire  [63:0] in_data_high,
  input  wire  [63:0] in_data_low,
  input  wire  [63:0] in_counter_high,
  input  wire  [63:0] in_counter_low,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  output logic [63:0] out_next_counter_high,
  output logic [63:0] out_next_counter_low
);
  import aes_pkg::*;

  // Key expansion: one schedule step per cycle after a key write.
  block_t     key_r, kexp_r;
  logic [3:0] kcnt_r;
  logic       kbusy_r;
  block_t     ekey_r [NumRounds + 1];
  block_t     dkey_r [NumRounds];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      kbusy_r <= 1'b0;
      kcnt_r  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == 1'b0) key_r[127:64] <= cfg_data;
      else                   key_r[63:0]   <= cfg_data;
      kbusy_r <= 1'b1;
      kcnt_r  <= '0;
    end else if (kbusy_r) begin
      kcnt_r <= kcnt_r + 4'd1;
      if (kcnt_r == 4'(NumRounds - 1)) kbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_valid) begin
      kexp_r <= (cfg_index == 1'b0) ? {cfg_data, key_r[63:0]} : {key_r[127:64], cfg_data};
      ekey_r[0] <= (cfg_index == 1'b0) ? {cfg_data, key_r[63:0]} : {key_r[127:64], cfg_data};
    end else if (kbusy_r) begin
      kexp_r <= key_step(kexp_r, kcnt_r);
      ekey_r[kcnt_r + 4'd1] <= key_step(kexp_r, kcnt_r);
      // Equivalent inverse cipher: decrypt round r uses InvMix of key 10-r.
      dkey_r[4'(NumRounds - 1) - kcnt_r] <= mix_inv(kexp_r);
    end
  end

  // Pipeline: stage 0 adds the first key (the last round key for decryption), stages 1..10 run rounds.
  stage_ctl_t ctl [NumRounds + 1];
  block_t     st [NumRounds + 1];
  block_t     cnt [NumRounds + 1];
  block_t     dat [NumRounds + 1];
  stage_ctl_t ctl0_r;
  block_t     st0_r, cnt0_r, dat0_r, src0;
  logic       adv;
  logic       out_valid_r;
  block_t     res_r, ncnt_r, res_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !kbusy_r && !cfg_valid;

  always_comb begin
    src0 = (in_kind == KIND_CTR) ? {in_counter_high, in_counter_low}
                                 : {in_data_high, in_data_low};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (adv) begin
      ctl0_r.vld  <= in_valid && in_ready;
      ctl0_r.kind <= kind_t'(in_kind);
    end
    if (adv) begin
      st0_r  <= src0 ^ ((kind_t'(in_kind) == KIND_DEC) ? ekey_r[NumRounds] : ekey_r[0]);
      cnt0_r <= {in_counter_high, in_counter_low};
      dat0_r <= {in_data_high, in_data_low};
    end
  end

  assign ctl[0] = ctl0_r;
  assign st[0]  = st0_r;
  assign cnt[0] = cnt0_r;
  assign dat[0] = dat0_r;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes_round u_rnd (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .last    (g == NumRounds),
      .ctl_in  (ctl[g - 1]),
      .st_in   (st[g - 1]),
      .cnt_in  (cnt[g - 1]),
      .dat_in  (dat[g - 1]),
      .enc_key (ekey_r[g]),
      .dec_key ((g == NumRounds) ? ekey_r[0] : dkey_r[g - 1]),
      .ctl_out (ctl[g]),
      .st_out  (st[g]),
      .cnt_out (cnt[g]),
      .dat_out (dat[g])
    );
  end

  always_comb begin
    unique case (ctl[NumRounds].kind)
      KIND_ENC, KIND_DEC: res_nxt = st[NumRounds];
      KIND_CTR:           res_nxt = st[NumRounds] ^ dat[NumRounds];
      default:            res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl[NumRounds].vld;
    end
    if (adv) begin
      res_r  <= res_nxt;
      ncnt_r <= cnt[NumRounds] + 128'd1;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_high       = res_r[127:64];
  assign out_result_low        = res_r[63:0];
  assign out_next_counter_high = ncnt_r[127:64];
  assign out_next_counter_low  = ncnt_r[63:0];
endmodule
`default_nettype wire

// File: hdl/aes_checker.sv
// Port-level checker for the AES-128 unit, bound to the top level.
// Depends on aes128_block_cipher_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "aes128_block_cipher_unit_defines.svh"
module aes_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        cfg_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [63:0] out_result_high
);
  `AES_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_result_high), "stalled result changed")
  `AES_ASSERT_IMP(a_stall, clk, rst_n, out_valid && !out_ready, !in_ready, "input taken while output stalled")
  `AES_ASSERT_NXT(a_cfg_block, clk, rst_n, cfg_valid, !in_ready, "input taken during key expansion")
endmodule

bind aes128_block_cipher_unit aes_checker u_chk (
  .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid),
  .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
  .out_result_high(out_result_high)
);
`default_nettype wire

// File: verif/aes128_block_cipher_unit_tb.sv
// Self-checking testbench for the AES-128 ECB/CTR unit: directed and random blocks
// under several keys, checked against an in-bench cipher model. Depends on aes_pkg.
`timescale 1ns / 1ps
module aes128_block_cipher_unit_tb;
  import aes_pkg::*;

  localparam int unsigned ItemsPerPhase = 175;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned StallLimit = 5000;
  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow = 1'b1;

  localparam bit [7:0] SBOX_TABLE [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  typedef struct {
    bit [63:0] res_hi;
    bit [63:0] res_lo;
    bit [63:0] ctr_hi;
    bit [63:0] ctr_lo;
  } cipher_out_t;

  class aes_scoreboard;
    bit [7:0] inv_sb [256];
    bit [127:0] round_key [20];
    bit [63:0] key_hi;
    bit [63:0] key_lo;
    cipher_out_t expected_blocks [$];
    int errors;

    function new();
      for (int i = 0; i < 256; i++) inv_sb[SBOX_TABLE[i]] = 8'(i);
      key_hi = '0;
      key_lo = '0;
      errors = 0;
    endfunction

    function bit [7:0] byte_at(bit [127:0] s, int i);
      return s[127 - 8 * i -: 8];
    endfunction

    function bit [7:0] gf_mul(bit [7:0] a, bit [7:0] b);
      bit [8:0] x;
      bit [7:0] p;
      x = {1'b0, a};
      p = '0;
      for (int i = 0; i < 8; i++) begin
        if (b[i]) p ^= x[7:0];
        x = x << 1;
        if (x[8]) x ^= 9'h11b;
      end
      return p;
    endfunction

    function bit [127:0] sub_shift(bit [127:0] s);
      bit [127:0] t;
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[127 - 8 * (4 * c + r) -: 8] = SBOX_TABLE[byte_at(s, 4 * ((c + r) % 4) + r)];
      return t;
    endfunction

    function bit [127:0] inv_sub_shift(bit [127:0] s);
      bit [127:0] t;
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = inv_sb[byte_at(s, 4 * c + r)];
      return t;
    endfunction

    function bit [127:0] mix_columns(bit [127:0] s, bit inverse);
      bit [7:0] fwd_coef [4] = '{8'd2, 8'd3, 8'd1, 8'd1};
      bit [7:0] inv_coef [4] = '{8'd14, 8'd11, 8'd13, 8'd9};
      bit [127:0] t;
      bit [7:0] v;
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) begin
          v = '0;
          for (int j = 0; j < 4; j++)
            v ^= gf_mul(inverse ? inv_coef[(j - r) & 3] : fwd_coef[(j - r) & 3],
                        byte_at(s, 4 * c + j));
          t[127 - 8 * (4 * c + r) -: 8] = v;
        end
      return t;
    endfunction

    // Any key register write re-derives the whole schedule from both halves.
    function void write_key(logic [0:0] idx, bit [63:0] value);
      bit [7:0] w [176];
      bit [7:0] t [4];
      bit [7:0] f;
      bit [127:0] k;
      bit [7:0] rc;
      if (idx == RegKeyHigh) key_hi = value;
      else key_lo = value;
      for (int i = 0; i < 16; i++) w[i] = byte_at({key_hi, key_lo}, i);
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
        for (int j = 0; j < 4; j++) t[j] = w[4 * (i - 1) + j];
        if (i % 4 == 0) begin
          f = t[0];
          t[0] = SBOX_TABLE[t[1]] ^ rc;
          t[1] = SBOX_TABLE[t[2]];
          t[2] = SBOX_TABLE[t[3]];
          t[3] = SBOX_TABLE[f];
          rc = gf_mul(rc, 8'h02);
        end
        for (int j = 0; j < 4; j++) w[4 * i + j] = w[4 * (i - 4) + j] ^ t[j];
      end
      for (int i = 0; i <= 10; i++) begin
        for (int j = 0; j < 16; j++) k[127 - 8 * j -: 8] = w[16 * i + j];
        round_key[i] = k;
      end
      for (int i = 11; i <= 19; i++) begin
        for (int j = 0; j < 16; j++) k[127 - 8 * j -: 8] = w[16 * (20 - i) + j];
        round_key[i] = mix_columns(k, 1'b1);
      end
    endfunction

    function bit [127:0] encrypt(bit [127:0] s);
      s ^= round_key[0];
      for (int r = 1; r <= 9; r++) s = mix_columns(sub_shift(s), 1'b0) ^ round_key[r];
      return sub_shift(s) ^ round_key[10];
    endfunction

    // Equivalent inverse cipher, using the pre-mixed decryption keys.
    function bit [127:0] decrypt(bit [127:0] s);
      s ^= round_key[10];
      for (int r = 11; r <= 19; r++) s = mix_columns(inv_sub_shift(s), 1'b1) ^ round_key[r];
      return inv_sub_shift(s) ^ round_key[0];
    endfunction

    function void note_input(kind_t kind, bit [63:0] dh, bit [63:0] dl,
                             bit [63:0] ch, bit [63:0] cl);
      cipher_out_t e;
      bit [127:0] blk;
      case (kind)
        KIND_ENC: blk = encrypt({dh, dl});
        KIND_DEC: blk = decrypt({dh, dl});
        KIND_CTR: blk = encrypt({ch, cl}) ^ {dh, dl};
        default:  blk = '0;
      endcase
      e.res_hi = blk[127:64];
      e.res_lo = blk[63:0];
      {e.ctr_hi, e.ctr_lo} = {ch, cl} + 128'd1;
      expected_blocks.push_back(e);
    endfunction

    function void compare_field(string name, bit [63:0] exp_v, bit [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %h actual %h", $realtime, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [63:0] rh, logic [63:0] rl,
                               logic [63:0] nh, logic [63:0] nl);
      cipher_out_t e;
      if (expected_blocks.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none actual %h%h", $realtime, rh, rl);
        return;
      end
      e = expected_blocks.pop_front();
      compare_field("result_high", e.res_hi, rh);
      compare_field("result_low", e.res_lo, rl);
      compare_field("next_counter_high", e.ctr_hi, nh);
      compare_field("next_counter_low", e.ctr_lo, nl);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_kind;
  logic [63:0] in_data_high;
  logic [63:0] in_data_low;
  logic [63:0] in_counter_high;
  logic [63:0] in_counter_low;
  logic out_valid;
  logic out_ready;
  logic [63:0] out_result_high;
  logic [63:0] out_result_low;
  logic [63:0] out_next_counter_high;
  logic [63:0] out_next_counter_low;

  aes_scoreboard cipher_sb = new();
  bit idling_on;
  int unsigned quiet_cycles;

  aes128_block_cipher_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_data_high(in_data_high), .in_data_low(in_data_low),
    .in_counter_high(in_counter_high), .in_counter_low(in_counter_low),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_high(out_result_high), .out_result_low(out_result_low),
    .out_next_counter_high(out_next_counter_high),
    .out_next_counter_low(out_next_counter_low)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result checking and the no-progress watchdog.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      cipher_sb.check_result(out_result_high, out_result_low,
                             out_next_counter_high, out_next_counter_low);
    if (!rst_n || (out_valid && out_ready) || (in_valid && in_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver back-pressure in random bursts.
  initial begin
    int unsigned n;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 15);
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
        out_ready = 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(negedge clk);
      end
    end
  end

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic wait_drained();
    while (cipher_sb.expected_blocks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, bit [63:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    cipher_sb.write_key(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_key(bit [63:0] hi, bit [63:0] lo);
    // The last transfer may have left in_valid high; drop it before draining.
    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    write_reg(RegKeyHigh, hi);
    write_reg(RegKeyLow, lo);
  endtask

  // Leaves in_valid high on return so back-to-back items keep it asserted.
  task automatic send_block(kind_t kind, bit [63:0] dh, bit [63:0] dl,
                            bit [63:0] ch, bit [63:0] cl);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_kind = kind;
    in_data_high = dh;
    in_data_low = dl;
    in_counter_high = ch;
    in_counter_low = cl;
    do @(posedge clk); while (!in_ready);
    cipher_sb.note_input(kind, dh, dl, ch, cl);
  endtask

  task automatic send_random_block();
    int unsigned sel;
    kind_t kind;
    bit [63:0] cl;
    sel = $urandom_range(0, 15);
    kind = (sel == 15) ? KIND_NONE : kind_t'(sel % 3);
    cl = ($urandom_range(0, 19) == 0) ? 64'hffff_ffff_ffff_fffe + $urandom_range(0, 1)
                                      : rand64();
    send_block(kind, rand64(), rand64(), rand64(), cl);
  endtask

  initial begin
    bit [63:0] k_hi;
    bit [63:0] k_lo;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = RegKeyHigh;
    cfg_data = '0;
    in_valid = 1'b0;
    in_kind = KIND_ENC;
    in_data_high = '0;
    in_data_low = '0;
    in_counter_high = '0;
    in_counter_low = '0;
    idling_on = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Standard test key and plaintext first, then field extremes in every mode.
    load_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
    send_block(KIND_ENC, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, '0, '0);
    send_block(KIND_DEC, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a, '0, '0);
    send_block(KIND_CTR, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff,
               64'hf0f1_f2f3_f4f5_f6f7, 64'hf8f9_fafb_fcfd_feff);
    send_block(KIND_NONE, '1, '1, '1, '1);
    send_block(KIND_ENC, '0, '0, '0, '0);
    send_block(KIND_ENC, '1, '1, '1, '0);
    send_block(KIND_DEC, '0, '0, '0, '1);
    send_block(KIND_DEC, '1, '1, '1, '1);
    send_block(KIND_CTR, '0, '0, '1, '1);
    send_block(KIND_CTR, '1, '1, '0, '0);
    send_block(KIND_CTR, rand64(), rand64(), 64'h1234, '1);
    send_block(KIND_NONE, '0, '0, '0, '0);
    send_block(KIND_ENC, 64'h8000_0000_0000_0000, 64'h1, 64'h8000_0000_0000_0000, 64'h1);

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin k_hi = '0; k_lo = '0; end
        1: begin k_hi = '1; k_lo = '1; end
        2: begin k_hi = '0; k_lo = '1; end
        default: begin k_hi = rand64(); k_lo = rand64(); end
      endcase
      idling_on = (p != NumPhases - 1);
      load_key(k_hi, k_lo);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        send_random_block();
        if (p == 2 && i == ItemsPerPhase / 2) begin
          // Hold the sender until the pipeline has emptied.
          @(negedge clk);
          in_valid = 1'b0;
          while (cipher_sb.expected_blocks.size() != 0) @(posedge clk);
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    idling_on = 1'b0;
    wait_drained();
    if (cipher_sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/aes_pkg.sv
hdl/aes_round.sv
hdl/aes128_block_cipher_unit.sv
hdl/aes_checker.sv
verif/aes128_block_cipher_unit_tb.sv
